// ===== hw/rtl/cgcb_pkg.sv =====
`default_nettype none
package cgcb_pkg;

  localparam int unsigned MaxCells      = 4096;
  localparam int unsigned MaxGroupAtoms = 16;
  localparam int unsigned MaxGroups     = 65536;

  localparam int unsigned PosW     = 32;
  localparam int unsigned SumW     = 38;
  localparam int unsigned RegW     = 31;
  localparam int unsigned ShapeW   = 12;
  localparam int unsigned GrpW     = 16;
  localparam int unsigned CellIdxW = 12;
  localparam int unsigned AtomCntW = 20;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegBoxX   = 3'd0;
  localparam logic [2:0] RegBoxY   = 3'd1;
  localparam logic [2:0] RegBoxZ   = 3'd2;
  localparam logic [2:0] RegCplX   = 3'd3;
  localparam logic [2:0] RegCplY   = 3'd4;
  localparam logic [2:0] RegCplZ   = 3'd5;
  localparam logic [2:0] RegShape  = 3'd6;

  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [PosW-1:0] pos_z;
    logic            last_atom;
    logic            new_pass;
  } atom_req_t;

  typedef struct packed {
    logic [GrpW-1:0]     group_number;
    logic [CellIdxW-1:0] cell_index;
    logic [GrpW-1:0]     slot_in_cell;
    logic [AtomCntW-1:0] cell_atoms;
    logic                group_oversize;
  } bin_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cgcb_atom_if.sv =====
`default_nettype none
interface cgcb_atom_if import cgcb_pkg::*; ();
  logic      valid;
  logic      ready;
  atom_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cgcb_res_if.sv =====
`default_nettype none
interface cgcb_res_if import cgcb_pkg::*; ();
  logic     valid;
  logic     ready;
  bin_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cgcb_divider.sv =====
`default_nettype none
// Restoring divider of a signed sum by a small positive count, one quotient
// bit per cycle, quotient rounded toward minus infinity.
module cgcb_divider import cgcb_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [SumW-1:0] dividend_i,
  input  wire logic [6:0]      divisor_i,
  output logic                 done_o,
  output logic [SumW-1:0]      quotient_o
);
  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] mag_q, mag_d;
  logic [7:0]      rem_q, rem_d;
  logic [6:0]      dvs_q;
  logic            neg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [7:0]      trial;
  logic [SumW-1:0] q_fix;

  always_comb begin
    trial  = {rem_q[6:0], mag_q[SumW-1]};
    mag_d  = {mag_q[SumW-2:0], 1'b0};
    rem_d  = trial;
    if (trial >= {1'b0, dvs_q}) begin
      rem_d    = trial - {1'b0, dvs_q};
      mag_d[0] = 1'b1;
    end
    cnt_d  = cnt_q - 1'b1;
    busy_d = busy_q && (cnt_q != CntW'(1));
  end

  // Negative sums: negate the magnitude quotient and step down on remainder.
  always_comb begin
    q_fix = mag_q;
    if (neg_q) q_fix = ~mag_q + ((rem_q != 8'd0) ? SumW'(0) : SumW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumW);
      end else if (busy_q) begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SumW-1];
      mag_q <= dividend_i[SumW-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = q_fix;
endmodule
`default_nettype wire

// ===== hw/rtl/charge_group_cell_binning.sv =====
`default_nettype none
// A non-final atom is summed in the accumulate step before the next atom is accepted.
// A final atom then runs three divisions in the shared divider, one per axis, then wrap,
// scale and clamp per axis, then index, read, write and output steps; no atom is accepted
// until it is done. A later final atom waits in the index step while an earlier result is
// still held by the receiver.
// Reset is asynchronous, active low; a clearing sweep over all MAX_CELLS cells follows reset
// and every new pass request, before that request is summed.
module charge_group_cell_binning import cgcb_pkg::*; #(
  parameter int unsigned MAX_CELLS       = MaxCells,
  parameter int unsigned MAX_GROUP_ATOMS = MaxGroupAtoms,
  parameter int unsigned MAX_GROUPS      = MaxGroups
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  cgcb_atom_if.sink        atom_in,
  cgcb_res_if.source       res_out
);
  localparam int unsigned CAW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned NW   = $clog2(MAX_GROUP_ATOMS + 1);
  localparam int unsigned GCap = (MAX_GROUPS > 65536) ? 65535 : MAX_GROUPS - 1;

  typedef enum logic [10:0] {
    StClear = 11'b00000000001,
    StIdle  = 11'b00000000010,
    StAcc   = 11'b00000000100,
    StDiv   = 11'b00000001000,
    StWait  = 11'b00000010000,
    StMul   = 11'b00000100000,
    StClamp = 11'b00001000000,
    StIdx   = 11'b00010000000,
    StRead  = 11'b00100000000,
    StWrite = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [RegW-1:0]   box_q [3];
  logic [RegW-1:0]   cpl_q [3];
  logic [ShapeW-1:0] shape_q;
  logic              wr_en;
  logic [2:0]        wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q   <= '{default: '0};
      cpl_q   <= '{default: '0};
      shape_q <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        RegBoxX:  box_q[0] <= pwdata[RegW-1:0];
        RegBoxY:  box_q[1] <= pwdata[RegW-1:0];
        RegBoxZ:  box_q[2] <= pwdata[RegW-1:0];
        RegCplX:  cpl_q[0] <= pwdata[RegW-1:0];
        RegCplY:  cpl_q[1] <= pwdata[RegW-1:0];
        RegCplZ:  cpl_q[2] <= pwdata[RegW-1:0];
        RegShape: shape_q  <= pwdata[ShapeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      RegBoxX:  prdata = {1'b0, box_q[0]};
      RegBoxY:  prdata = {1'b0, box_q[1]};
      RegBoxZ:  prdata = {1'b0, box_q[2]};
      RegCplX:  prdata = {1'b0, cpl_q[0]};
      RegCplY:  prdata = {1'b0, cpl_q[1]};
      RegCplZ:  prdata = {1'b0, cpl_q[2]};
      RegShape: prdata = {20'd0, shape_q};
      default:  prdata = '0;
    endcase
  end

  // Group accumulation state.
  atom_req_t         req_q;
  logic              pass_q;
  logic [SumW-1:0]   sum_q [3];
  logic [NW-1:0]     n_q;
  logic              big_q;
  logic [GrpW-1:0]   grp_q;
  logic [CAW:0]      clr_q;
  logic [1:0]        ax_q;
  logic [SumW-1:0]   ctr_q [3];
  logic [3:0]        cc_q [3];
  logic [SumW-1:0]   div_q;
  logic              div_start;
  logic              div_done;
  logic [SumW-1:0]   wrap;
  logic [PosW-1:0]   mul_a;
  logic [PosW+RegW-1:0] prod_q;
  logic [3:0]        last;
  logic [RegW-1:0]   kint;
  logic [13:0]       lin_full;
  logic [CAW-1:0]    addr_q;
  logic [GrpW-1:0]   gcnt_rd_q;
  logic [AtomCntW-1:0] acnt_rd_q;
  logic [AtomCntW:0] asum;
  logic [AtomCntW-1:0] anew;
  bin_res_t          res_q;
  logic              res_vld_q;
  logic [GrpW-1:0]   gmem [MAX_CELLS];
  logic [AtomCntW-1:0] amem [MAX_CELLS];
  logic              mem_we;
  logic [CAW-1:0]    mem_wa;
  logic [GrpW-1:0]   mem_wg;
  logic [AtomCntW-1:0] mem_wa_d;

  assign atom_in.ready = (state_q == StIdle);
  assign res_out.valid = res_vld_q;
  assign res_out.data  = res_q;

  cgcb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[ax_q]),
    .divisor_i  (7'(n_q)),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign div_start = (state_q == StDiv);

  // Wrap and scale operand of the current axis; still negative centers go to zero.
  always_comb begin
    wrap = ctr_q[ax_q];
    if (wrap[SumW-1]) wrap = wrap + SumW'(box_q[ax_q]);
    mul_a = wrap[SumW-1] ? '0 : wrap[PosW-1:0];
    unique case (ax_q)
      2'd0:    last = shape_q[3:0];
      2'd1:    last = shape_q[7:4];
      default: last = shape_q[11:8];
    endcase
    kint = prod_q[PosW+RegW-1:PosW];
  end

  // Linear cell index, z-major.
  assign lin_full = (14'(cc_q[2]) * (14'(shape_q[7:4]) + 14'd1) + 14'(cc_q[1]))
                    * (14'(shape_q[3:0]) + 14'd1) + 14'(cc_q[0]);

  assign asum = {1'b0, acnt_rd_q} + (AtomCntW+1)'(n_q);
  assign anew = asum[AtomCntW] ? '1 : asum[AtomCntW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == (CAW+1)'(MAX_CELLS - 1)) state_d = pass_q ? StAcc : StIdle;
      StIdle:  if (atom_in.valid && atom_in.ready) state_d = atom_in.data.new_pass ?
                                                       StClear : StAcc;
      StAcc:   state_d = req_q.last_atom ? StDiv : StIdle;
      StDiv:   state_d = StWait;
      StWait:  if (div_done) state_d = (ax_q == 2'd2) ? StMul : StDiv;
      StMul:   state_d = StClamp;
      StClamp: state_d = (ax_q == 2'd2) ? StIdx : StMul;
      StIdx:   if (!res_vld_q) state_d = StRead;
      StRead:  state_d = StWrite;
      StWrite: state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = addr_q;
    mem_wg   = '0;
    mem_wa_d = '0;
    if (state_q == StClear) begin
      mem_we = 1'b1;
      mem_wa = clr_q[CAW-1:0];
    end else if (state_q == StWrite) begin
      mem_we   = 1'b1;
      mem_wg   = (gcnt_rd_q == '1) ? gcnt_rd_q : gcnt_rd_q + 1'b1;
      mem_wa_d = anew;
    end
  end

  // Counter memories, one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      gmem[mem_wa] <= mem_wg;
      amem[mem_wa] <= mem_wa_d;
    end
    gcnt_rd_q <= gmem[addr_q];
    acnt_rd_q <= amem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      pass_q    <= 1'b0;
      clr_q     <= '0;
      sum_q     <= '{default: '0};
      n_q       <= '0;
      big_q     <= 1'b0;
      grp_q     <= '0;
      ax_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_out.valid && res_out.ready) res_vld_q <= 1'b0;
      unique case (state_q)
        StClear: clr_q <= clr_q + 1'b1;
        StIdle: begin
          clr_q <= '0;
          if (atom_in.valid && atom_in.ready) begin
            pass_q <= atom_in.data.new_pass;
            if (atom_in.data.new_pass) begin
              sum_q <= '{default: '0};
              n_q   <= '0;
              big_q <= 1'b0;
              grp_q <= '0;
            end
          end
        end
        StAcc: begin
          ax_q <= '0;
          if (n_q < NW'(MAX_GROUP_ATOMS)) begin
            sum_q[0] <= sum_q[0] + SumW'(signed'(req_q.pos_x));
            sum_q[1] <= sum_q[1] + SumW'(signed'(req_q.pos_y));
            sum_q[2] <= sum_q[2] + SumW'(signed'(req_q.pos_z));
            n_q      <= n_q + 1'b1;
          end else begin
            big_q <= 1'b1;
          end
        end
        StWait:  if (div_done) ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
        StClamp: ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 1'b1;
        StOut: begin
          res_vld_q <= 1'b1;
          if (32'(grp_q) < GCap) grp_q <= grp_q + 1'b1;
          sum_q <= '{default: '0};
          n_q   <= '0;
          big_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (atom_in.valid && atom_in.ready) req_q <= atom_in.data;
    if (state_q == StWait && div_done) ctr_q[ax_q] <= div_q;
    // One multiply per axis, and the clamp of that axis in the following cycle.
    if (state_q == StMul) prod_q <= {{RegW{1'b0}}, mul_a} * {{PosW{1'b0}}, cpl_q[ax_q]};
    if (state_q == StClamp) begin
      if (kint > RegW'(last)) cc_q[ax_q] <= last;
      else cc_q[ax_q] <= kint[3:0];
    end
    // Index saturation, registered before the memory read.
    if (state_q == StIdx) begin
      addr_q <= (32'(lin_full) >= MAX_CELLS) ? CAW'(MAX_CELLS - 1) : CAW'(lin_full);
    end
    if (state_q == StRead) res_q.cell_index <= CellIdxW'(addr_q);
    if (state_q == StWrite) begin
      res_q.group_number   <= grp_q;
      res_q.slot_in_cell   <= gcnt_rd_q;
      res_q.cell_atoms     <= anew;
      res_q.group_oversize <= big_q;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !atom_in.ready) else $error("accept while busy");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.ready) |=> res_out.valid) else $error("result dropped");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_GROUP_ATOMS) else $error("atom count overflow");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_charge_group_cell_binning.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_charge_group_cell_binning;
  import cgcb_pkg::*;

  localparam int unsigned WatchLimit  = 50000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned SweepWait   = 5000;
  localparam int unsigned HoldOff     = 3000;
  localparam int unsigned PhaseItems  = 210;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  cgcb_atom_if atom_ch ();
  cgcb_res_if  bin_ch ();

  charge_group_cell_binning dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .atom_in (atom_ch.sink),
    .res_out (bin_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the configuration registers.
  int unsigned box_len [3];
  int unsigned cells_per_len [3];
  logic [11:0] shape_reg;

  // Shadow of the binning state.
  longint      grp_sum [3];
  int unsigned grp_atoms;
  bit          grp_big;
  int unsigned pass_groups;
  int unsigned cell_groups [MaxCells];
  int unsigned cell_atom_tot [MaxCells];

  bin_res_t    bins_due [$];

  int unsigned n_err = 0;
  int unsigned n_atoms = 0;
  int unsigned n_bins = 0;
  int unsigned n_passes = 0;
  int unsigned n_big = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  typedef struct {
    int          px;
    int          py;
    int          pz;
    bit          last;
    bit          pass;
    int unsigned count;
    bit          typed;
    bin_res_t    want;
  } dir_row_t;

  function automatic longint floor_quot(longint s, longint n);
    longint q;
    q = s / n;
    if ((s % n) != 0 && s < 0) q--;
    return q;
  endfunction

  // Wraps, scales and clamps one axis of a group center.
  function automatic int unsigned axis_bin(longint c, int unsigned box, int unsigned cpl,
                                           int unsigned top);
    longint k;
    if (c < 0) c += longint'(box);
    if (c < 0) return 0;
    k = (c * longint'(cpl)) >>> 32;
    if (k > longint'(top)) k = top;
    return int'(k);
  endfunction

  // Advances the shadow state by one atom and reports the bin it closes, if any.
  task automatic bin_atom(input atom_req_t a, output bit closes, output bin_res_t r);
    int unsigned dims [3];
    int unsigned cb [3];
    int unsigned idx;
    logic [31:0] p [3];
    p[0] = a.pos_x;
    p[1] = a.pos_y;
    p[2] = a.pos_z;
    closes = 1'b0;
    r = '0;
    if (a.new_pass) begin
      for (int i = 0; i < MaxCells; i++) begin
        cell_groups[i] = 0;
        cell_atom_tot[i] = 0;
      end
      pass_groups = 0;
      grp_sum = '{0, 0, 0};
      grp_atoms = 0;
      grp_big = 1'b0;
    end
    if (grp_atoms < MaxGroupAtoms) begin
      for (int i = 0; i < 3; i++) grp_sum[i] += longint'(signed'(p[i]));
      grp_atoms++;
    end else begin
      grp_big = 1'b1;
    end
    if (!a.last_atom) return;
    for (int i = 0; i < 3; i++) begin
      dims[i] = shape_reg[4*i +: 4] + 1;
      cb[i] = axis_bin(floor_quot(grp_sum[i], grp_atoms), box_len[i], cells_per_len[i],
                       dims[i] - 1);
    end
    idx = (cb[2] * dims[1] + cb[1]) * dims[0] + cb[0];
    if (idx >= MaxCells) idx = MaxCells - 1;
    r.group_number = pass_groups[15:0];
    r.cell_index = idx[11:0];
    r.slot_in_cell = cell_groups[idx][15:0];
    if (cell_groups[idx] < 65535) cell_groups[idx]++;
    cell_atom_tot[idx] += grp_atoms;
    if (cell_atom_tot[idx] > 1048575) cell_atom_tot[idx] = 1048575;
    r.cell_atoms = cell_atom_tot[idx][19:0];
    r.group_oversize = grp_big;
    if (pass_groups < 65535) pass_groups++;
    grp_sum = '{0, 0, 0};
    grp_atoms = 0;
    grp_big = 1'b0;
    closes = 1'b1;
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegBoxX: box_len[0] = val & 32'h7FFF_FFFF;
      RegBoxY: box_len[1] = val & 32'h7FFF_FFFF;
      RegBoxZ: box_len[2] = val & 32'h7FFF_FFFF;
      RegCplX: cells_per_len[0] = val & 32'h7FFF_FFFF;
      RegCplY: cells_per_len[1] = val & 32'h7FFF_FFFF;
      RegCplZ: cells_per_len[2] = val & 32'h7FFF_FFFF;
      RegShape: shape_reg = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_setting(input int unsigned k);
    logic [31:0] bx, cp;
    logic [11:0] sh;
    case (k)
      0: begin bx = 32'd10 << 16; cp = 32'd104858; sh = 12'hFFF; end
      1: begin bx = 32'd4 << 16; cp = 32'd49152; sh = 12'h142; end
      2: begin bx = 32'd0; cp = 32'd65536; sh = 12'h777; end
      3: begin bx = 32'hFFFF_FFFF; cp = 32'hFFFF_FFFF; sh = 12'hFFF; end
      4: begin bx = $urandom_range(1 << 22); cp = $urandom; sh = 12'($urandom); end
      default: begin bx = 32'd100 << 16; cp = 32'd9830; sh = 12'hAAA; end
    endcase
    write_reg(RegBoxX, bx);
    write_reg(RegBoxY, (k == 1) ? 32'd5 << 16 : bx);
    write_reg(RegBoxZ, (k == 1) ? 32'd2 << 16 : bx);
    write_reg(RegCplX, cp);
    write_reg(RegCplY, (k == 1) ? 32'd65536 : cp);
    write_reg(RegCplZ, (k == 1) ? 32'd65536 : cp);
    write_reg(RegShape, {20'd0, sh});
  endtask

  // Offers one atom, waits for its acceptance and records what it should produce.
  task automatic send_atom(input atom_req_t a);
    bit       closes;
    bin_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      atom_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    atom_ch.valid = 1'b1;
    atom_ch.data = a;
    @(posedge clk_i);
    while (!atom_ch.ready) @(posedge clk_i);
    bin_atom(a, closes, r);
    if (closes) bins_due.push_back(r);
    n_atoms++;
    if (a.new_pass) n_passes++;
    @(negedge clk_i);
    atom_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_pos(input int unsigned ax, input int unsigned mode);
    int unsigned span;
    logic [31:0] v;
    span = (box_len[ax] == 0) ? (1 << 20) : box_len[ax];
    if (mode == 0) return $urandom;
    v = $urandom_range(span);
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic send_group(input int unsigned n, input bit pass, input bit close);
    atom_req_t a;
    int unsigned mode;
    mode = ($urandom_range(4) == 0) ? 0 : 1;
    for (int i = 0; i < n; i++) begin
      a.pos_x = pick_pos(0, mode);
      a.pos_y = pick_pos(1, mode);
      a.pos_z = pick_pos(2, mode);
      a.new_pass = pass && (i == 0);
      a.last_atom = close && (i == n - 1);
      send_atom(a);
    end
  endtask

  task automatic wait_idle();
    while (bins_due.size() != 0) @(posedge clk_i);
    repeat (SweepWait) @(posedge clk_i);
  endtask

  // Receiver side: random stalls plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      bin_ch.ready = 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldOff;
      bin_ch.ready = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      bin_ch.ready = 1'b0;
    end else begin
      bin_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    bin_res_t want;
    if (rst_ni) begin
      if ((atom_ch.valid && atom_ch.ready) || (bin_ch.valid && bin_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (bin_ch.valid && bin_ch.ready) begin
        n_bins++;
        if (bin_ch.data.group_oversize) n_big++;
        if (bins_due.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %p", bin_ch.data);
        end else begin
          want = bins_due.pop_front();
          if (bin_ch.data.group_number !== want.group_number ||
              bin_ch.data.cell_index !== want.cell_index ||
              bin_ch.data.slot_in_cell !== want.slot_in_cell ||
              bin_ch.data.cell_atoms !== want.cell_atoms ||
              bin_ch.data.group_oversize !== want.group_oversize) begin
            n_err++;
            if (n_err <= 10) $display("mismatch: expected %p, got %p", want, bin_ch.data);
          end
        end
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("timeout with %0d results outstanding", bins_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  dir_row_t rows [8];

  initial begin
    atom_req_t a;
    bit        closes;
    bin_res_t  r;
    int unsigned n;

    atom_ch.valid = 1'b0;
    atom_ch.data = '0;
    box_len = '{0, 0, 0};
    cells_per_len = '{0, 0, 0};
    shape_reg = '0;
    grp_sum = '{0, 0, 0};
    grp_atoms = 0;
    grp_big = 1'b0;
    pass_groups = 0;
    for (int i = 0; i < MaxCells; i++) begin
      cell_groups[i] = 0;
      cell_atom_tot[i] = 0;
    end

    // With all registers at zero every group lands in cell 0.
    rows[0] = '{0, 0, 0, 1, 0, 1, 1, '{16'd0, 12'd0, 16'd0, 20'd1, 1'b0}};
    rows[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1, 1,
                '{16'd1, 12'd0, 16'd1, 20'd2, 1'b0}};
    rows[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 1, 1,
                '{16'd2, 12'd0, 16'd2, 20'd3, 1'b0}};
    rows[3] = '{7, -7, 3, 1, 0, 18, 1, '{16'd3, 12'd0, 16'd3, 20'd19, 1'b1}};
    rows[4] = '{5, 5, 5, 0, 0, 3, 0, '0};
    rows[5] = '{1, 2, 3, 1, 1, 1, 1, '{16'd0, 12'd0, 16'd0, 20'd1, 1'b0}};
    rows[6] = '{-1, -1, -1, 1, 0, 16, 1, '{16'd1, 12'd0, 16'd1, 20'd17, 1'b0}};
    rows[7] = '{32'h1234_5678, -32'sd65536, 32'h0000_FFFF, 1, 0, 2, 0, '0};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: a typed expectation overrides the shadow's answer.
    foreach (rows[k]) begin
      for (int i = 0; i < rows[k].count; i++) begin
        a.pos_x = rows[k].px;
        a.pos_y = rows[k].py;
        a.pos_z = rows[k].pz;
        a.new_pass = rows[k].pass && (i == 0);
        a.last_atom = rows[k].last && (i == rows[k].count - 1);
        atom_ch.valid = 1'b1;
        atom_ch.data = a;
        @(posedge clk_i);
        while (!atom_ch.ready) @(posedge clk_i);
        bin_atom(a, closes, r);
        if (closes) bins_due.push_back(rows[k].typed ? rows[k].want : r);
        n_atoms++;
        @(negedge clk_i);
        atom_ch.valid = 1'b0;
      end
    end

    // Random phases, each under its own register setting and one of four idling mixes.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      load_setting(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      n = 0;
      send_group(1, 1'b1, 1'b1);
      if (ph == 2) begin
        recv_stall_pct = 0;
        hold_req++;
      end
      while (n < PhaseItems) begin
        int unsigned sz;
        sz = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
        send_group(sz, $urandom_range(59) == 0, $urandom_range(19) != 0);
        n += sz;
        if (ph == 2 && hold_left == 0 && hold_seen == hold_req) recv_stall_pct = 85;
      end
    end

    while (bins_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d atoms over %0d passes; checked %0d binned groups, %0d oversize.",
             n_atoms, n_passes, n_bins, n_big);
    $display("Six register settings with zero and full-scale extremes, %0d mismatches.",
             n_err);
    if (n_err == 0 && bins_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/cgcb_pkg.sv
hw/rtl/cgcb_atom_if.sv
hw/rtl/cgcb_res_if.sv
hw/rtl/cgcb_divider.sv
hw/rtl/charge_group_cell_binning.sv
tb/sv/tb_charge_group_cell_binning.sv
